// ===== hw/rtl/ptrgb_pkg.sv =====
// Shared types, constants and the channel scaling function of the planar tile row decoder.
// Depends on nothing; every other file of the block but ptrgb_ram imports it.
`default_nettype none

package ptrgb_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int INDEX_W             = 8;
    localparam int COLOR_W             = 9;
    localparam int PLANES              = 4;
    localparam int PLANE_W             = 8;
    localparam int BANK_W              = 4;
    localparam int CHAN_W              = 8;
    localparam int X_W                 = 3;
    localparam int S_TDATA_W           = 64;
    localparam int M_TDATA_W           = 32;

    localparam logic [X_W-1:0] LAST_X  = 3'd7;
    localparam logic [X_W-1:0] FIRST_X = 3'd0;

    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_DECODE = 1'b1
    } action_t;

    // Control and position that travel beside the palette read data.
    typedef struct packed {
        logic            valid;
        logic [X_W-1:0]  x;
        logic            oob;
    } pix_meta_t;

    // floor(255 * c / 7) for a 3-bit channel.
    function automatic logic [CHAN_W-1:0] scale3(input logic [2:0] c);
        logic [CHAN_W-1:0] r;
        begin
            case (c)
                3'd0:    r = 8'd0;
                3'd1:    r = 8'd36;
                3'd2:    r = 8'd72;
                3'd3:    r = 8'd109;
                3'd4:    r = 8'd145;
                3'd5:    r = 8'd182;
                3'd6:    r = 8'd218;
                3'd7:    r = 8'd255;
                default: r = 8'd0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ptrgb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the palette.
`default_nettype none

module ptrgb_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ptrgb_seq.sv =====
// Input stage and pixel sequencer: holds one item, writes the palette or issues one
// palette read per pixel, and keeps the read-stage control. Depends on ptrgb_pkg.
`default_nettype none

module ptrgb_seq #(
    parameter int PALETTE_ENTRIES = ptrgb_pkg::PALETTE_ENTRIES_DEF,
    localparam int AW             = $clog2(PALETTE_ENTRIES)
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [ptrgb_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire logic                                 s_tuser,
    input  wire logic                                 s1_ready,
    output logic                                      ram_we,
    output logic      [AW-1:0]                        ram_waddr,
    output logic      [ptrgb_pkg::COLOR_W-1:0]        ram_wdata,
    output logic                                      ram_re,
    output logic      [AW-1:0]                        ram_raddr,
    output ptrgb_pkg::pix_meta_t                      s1_meta
);

    import ptrgb_pkg::*;

    localparam int                 CMP_W       = INDEX_W + 1;
    localparam logic [CMP_W-1:0]   ENTRY_LIMIT = CMP_W'(PALETTE_ENTRIES);

    // Stage 0 holds the accepted word.
    logic                               s0_valid_reg, s0_valid_next;
    action_t                            s0_action_reg;
    logic [INDEX_W-1:0]                 s0_index_reg;
    logic [COLOR_W-1:0]                 s0_color_reg;
    logic [PLANES-1:0][PLANE_W-1:0]     s0_planes_reg;
    logic [BANK_W-1:0]                  s0_bank_reg;
    logic [X_W-1:0]                     s0_x_reg, s0_x_next;
    pix_meta_t                          s1_meta_reg, s1_meta_next;

    logic                               accept;
    logic                               s1_advance;
    logic                               issue_read;
    logic                               done;
    logic [BANK_W-1:0]                  nib;
    logic [INDEX_W-1:0]                 rd_index;
    logic [PLANES-1:0][PLANE_W-1:0]     in_planes;
    logic [PLANE_W-1:0]                 in_attr;
    logic [BANK_W-1:0]                  in_bank;

    assign in_planes = s_tdata[48:17];
    assign in_attr   = s_tdata[56:49];
    assign in_bank   = s_tdata[57] ? in_attr[3:0] : in_attr[7:4];

    assign s1_advance = !s1_meta_reg.valid || s1_ready;
    assign issue_read = s0_valid_reg && (s0_action_reg == ACT_DECODE) && s1_advance;
    assign done       = s0_valid_reg &&
                        ((s0_action_reg == ACT_WRITE) || (issue_read && (s0_x_reg == LAST_X)));
    assign s_tready   = !s0_valid_reg || done;
    assign accept     = s_tvalid && s_tready;

    // Pixel x takes bit 7-x of every plane byte.
    always_comb
    begin
        for (int p = 0; p < PLANES; p++)
        begin
            nib[p] = s0_planes_reg[p][~s0_x_reg];
        end
    end

    assign rd_index  = {s0_bank_reg, nib};
    assign ram_re    = issue_read;
    assign ram_raddr = rd_index[AW-1:0];
    assign ram_we    = s0_valid_reg && (s0_action_reg == ACT_WRITE) &&
                       ({1'b0, s0_index_reg} < ENTRY_LIMIT);
    assign ram_waddr = s0_index_reg[AW-1:0];
    assign ram_wdata = s0_color_reg;

    always_comb
    begin
        s0_valid_next = s0_valid_reg;
        s0_x_next     = s0_x_reg;
        if (accept)
        begin
            s0_valid_next = 1'b1;
            s0_x_next     = FIRST_X;
        end
        else if (done)
        begin
            s0_valid_next = 1'b0;
        end
        else if (issue_read)
        begin
            s0_x_next = s0_x_reg + 3'd1;
        end
    end

    always_comb
    begin
        s1_meta_next = s1_meta_reg;
        if (s1_advance)
        begin
            s1_meta_next.valid = issue_read;
            s1_meta_next.x     = s0_x_reg;
            s1_meta_next.oob   = ({1'b0, rd_index} >= ENTRY_LIMIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s0_x_reg     <= FIRST_X;
            s1_meta_reg  <= '0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s0_x_reg     <= s0_x_next;
            s1_meta_reg  <= s1_meta_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_action_reg <= action_t'(s_tuser);
            s0_index_reg  <= s_tdata[7:0];
            s0_color_reg  <= s_tdata[16:8];
            s0_planes_reg <= in_planes;
            s0_bank_reg   <= in_bank;
        end
    end

    assign s1_meta = s1_meta_reg;

`ifndef SYNTHESIS
    // A stalled decode keeps its pixel position.
    a_stall_holds_x: assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid_reg && (s0_action_reg == ACT_DECODE) && !s1_advance
        |=> s0_x_reg == $past(s0_x_reg))
        else $error("pixel position moved during a stall");

    // Every issued read shows up as a valid entry of the read stage.
    a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
        issue_read |=> s1_meta_reg.valid)
        else $error("issued palette read was lost");

    // A palette write leaves stage 0 in the cycle it is performed.
    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid_reg && (s0_action_reg == ACT_WRITE) |-> s_tready)
        else $error("palette write held the input stage");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ptrgb_out.sv =====
// Output stage: scales the palette colour to RGB8 and holds the result word.
// Depends on ptrgb_pkg.
`default_nettype none

module ptrgb_out (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ptrgb_pkg::pix_meta_t              s1_meta,
    input  wire logic [ptrgb_pkg::COLOR_W-1:0]     rdata,
    output logic                                   s1_ready,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [ptrgb_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                                   m_tlast
);

    import ptrgb_pkg::*;

    logic                 valid_reg, valid_next;
    logic [CHAN_W-1:0]    red_reg, green_reg, blue_reg;
    logic [X_W-1:0]       x_reg;
    logic                 last_reg;
    logic                 advance;
    logic [COLOR_W-1:0]   color;

    assign advance    = !valid_reg || m_tready;
    assign s1_ready   = advance;
    assign valid_next = advance ? s1_meta.valid : valid_reg;
    // An index beyond the palette reads as black.
    assign color      = s1_meta.oob ? '0 : rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_meta.valid)
        begin
            red_reg   <= scale3(color[5:3]);
            green_reg <= scale3(color[8:6]);
            blue_reg  <= scale3(color[2:0]);
            x_reg     <= s1_meta.x;
            last_reg  <= (s1_meta.x == LAST_X);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'b0, x_reg, blue_reg, green_reg, red_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/planar_tile_row_to_rgb_top.sv =====
// Top level of the planar tile row to RGB decoder with its 9-bit palette.
// Depends on ptrgb_pkg, ptrgb_seq, ptrgb_ram and ptrgb_out.
`default_nettype none

// Each input word either writes one palette entry (tuser low) or decodes one row of a
// four-bitplane 8x8 tile (tuser high). A decode yields eight output words, pixel 0 to
// pixel 7 from left to right, with tlast on pixel 7; a palette write yields none. The
// palette bank comes from the high nibble of the attribute byte for even columns and
// the low nibble for odd columns, and each 3-bit channel is scaled to floor(255*c/7).
// A palette write leaves the sequencer in the cycle it is done; a row decode issues one
// read per pixel, since the palette has a single read port and each pixel needs its own
// read. Back-to-back rows therefore stream one pixel per cycle while the output is not
// stalled, each pixel passing the palette read and output registers in turn. Writes and
// reads go through the same in-order sequencer, so a decode always sees every palette
// write accepted before it. Palette contents after reset are undefined until written;
// there is no clearing pass, and the block is ready as soon as reset is released.
module planar_tile_row_to_rgb_top #(
    parameter int PALETTE_ENTRIES = ptrgb_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // entry_index[7:0], color_word[16:8], plane_zero[24:17], plane_one[32:25],
    // plane_two[40:33], plane_three[48:41], attr_byte[56:49], odd_column[57], zeros above
    input  wire logic [ptrgb_pkg::S_TDATA_W-1:0]    s_tdata,
    // action[0]
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // red[7:0], green[15:8], blue[23:16], pixel_x[26:24], zeros above
    output logic      [ptrgb_pkg::M_TDATA_W-1:0]    m_tdata,
    // last
    output logic                                    m_tlast
);

    import ptrgb_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [COLOR_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [COLOR_W-1:0]  ram_rdata;
    logic                s1_ready;
    pix_meta_t           s1_meta;

    ptrgb_seq #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s1_ready  (s1_ready),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .s1_meta   (s1_meta)
    );

    // Palette memory.
    ptrgb_ram #(
        .WIDTH(COLOR_W),
        .DEPTH(PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ptrgb_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_meta  (s1_meta),
        .rdata    (ram_rdata),
        .s1_ready (s1_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
